[rtl/ppmd_pkg.sv]
// Shared types, register indexes and constants of the PPM frame decoder.
package ppmd_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = $clog2(CHANNELS);

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_SYNC     = 3'd1,
    ST_STORED   = 3'd2,
    ST_JUMP     = 3'd3,
    ST_BADWIDTH = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  localparam logic [2:0] REG_WATCHED_PIN   = 3'd0;
  localparam logic [2:0] REG_FRAME_GAP_MIN = 3'd1;
  localparam logic [2:0] REG_PULSE_MIN     = 3'd2;
  localparam logic [2:0] REG_PULSE_MAX     = 3'd3;
  localparam logic [2:0] REG_JUMP_PERCENT  = 3'd4;

  localparam logic [15:0] RST_WATCHED_PIN   = 16'd256;
  localparam logic [19:0] RST_FRAME_GAP_MIN = 20'd2500;
  localparam logic [15:0] RST_PULSE_MIN     = 16'd1000;
  localparam logic [15:0] RST_PULSE_MAX     = 16'd2000;
  localparam logic [6:0]  RST_JUMP_PERCENT  = 7'd15;

  localparam logic [15:0] LAST_RESET = 16'd1500;
  localparam logic [6:0]  PCT_SCALE  = 7'd100;

  typedef struct packed {
    logic [15:0] watched_pin;
    logic [19:0] frame_gap_min;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [6:0]  jump_percent;
  } cfg_t;

  // stick and switch order: source channel for each mapped output
  function automatic logic [CH_W-1:0] map_src(input logic [CH_W-1:0] slot);
    logic [CH_W-1:0] src;
    unique case (slot)
      3'd2:    src = 3'd3;
      3'd3:    src = 3'd2;
      default: src = slot;
    endcase
    return src;
  endfunction

endpackage

[rtl/ppmd_cfg.sv]
// Configuration registers of the PPM frame decoder behind an APB-style port.
module ppmd_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ppmd_pkg::cfg_t      cfg
);

  ppmd_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watched_pin   <= ppmd_pkg::RST_WATCHED_PIN;
      cfg_r.frame_gap_min <= ppmd_pkg::RST_FRAME_GAP_MIN;
      cfg_r.pulse_min     <= ppmd_pkg::RST_PULSE_MIN;
      cfg_r.pulse_max     <= ppmd_pkg::RST_PULSE_MAX;
      cfg_r.jump_percent  <= ppmd_pkg::RST_JUMP_PERCENT;
    end else if (wr_en) begin
      unique case (reg_idx)
        ppmd_pkg::REG_WATCHED_PIN:   cfg_r.watched_pin   <= pwdata[15:0];
        ppmd_pkg::REG_FRAME_GAP_MIN: cfg_r.frame_gap_min <= pwdata[19:0];
        ppmd_pkg::REG_PULSE_MIN:     cfg_r.pulse_min     <= pwdata[15:0];
        ppmd_pkg::REG_PULSE_MAX:     cfg_r.pulse_max     <= pwdata[15:0];
        ppmd_pkg::REG_JUMP_PERCENT:  cfg_r.jump_percent  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ppmd_pkg::REG_WATCHED_PIN:   prdata = {16'd0, cfg_r.watched_pin};
      ppmd_pkg::REG_FRAME_GAP_MIN: prdata = {12'd0, cfg_r.frame_gap_min};
      ppmd_pkg::REG_PULSE_MIN:     prdata = {16'd0, cfg_r.pulse_min};
      ppmd_pkg::REG_PULSE_MAX:     prdata = {16'd0, cfg_r.pulse_max};
      ppmd_pkg::REG_JUMP_PERCENT:  prdata = {25'd0, cfg_r.jump_percent};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

[rtl/ppmd_core.sv]
// Decode state, glitch filter and result register of the PPM frame decoder.
module ppmd_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ppmd_pkg::cfg_t                         cfg,
  input  logic                                   item_valid,
  input  logic [15:0]                            item_pin,
  input  logic [31:0]                            item_time,
  output logic                                   take,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [2:0]                             out_status,
  output logic [3:0]                             out_channels_seen,
  output logic                                   out_sync_flag,
  output logic [ppmd_pkg::CHANNELS-1:0][15:0]    out_mapped
);

  localparam int CW = ppmd_pkg::CH_W;
  localparam int NC = ppmd_pkg::CHANNELS;

  logic [31:0]    prev_time_r;
  logic           ready_r, ready_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           sync_r, sync_nxt;
  logic [15:0]    store_r  [NC];
  logic [15:0]    last_r   [NC];
  logic [15:0]    mapped_r [NC];
  logic           out_valid_r;
  ppmd_pkg::status_t status_r, status_nxt;
  logic [3:0]     seen_r, seen_nxt;

  logic           hit, gap, bad, jump, store_en, done;
  logic [31:0]    delta;
  logic [15:0]    val, old, diff;
  logic [22:0]    thr_prod, lim_prod;

  assign take = item_valid && (!out_valid_r || out_ready);

  always_comb begin
    hit      = item_pin == cfg.watched_pin;
    delta    = item_time - prev_time_r;
    gap      = delta >= {12'd0, cfg.frame_gap_min};
    bad      = (delta < {16'd0, cfg.pulse_min}) || (delta > {16'd0, cfg.pulse_max});
    val      = delta[15:0];
    old      = last_r[idx_r];
    diff     = (val >= old) ? (val - old) : (old - val);
    // diff > floor(old*pct/100) exactly when old*pct < diff*100
    thr_prod = {7'd0, old} * {16'd0, cfg.jump_percent};
    lim_prod = {7'd0, diff} * {16'd0, ppmd_pkg::PCT_SCALE};
    jump     = (idx_r != '0) && (old != 16'd0) && (thr_prod < lim_prod);

    ready_nxt  = ready_r;
    idx_nxt    = idx_r;
    sync_nxt   = sync_r;
    status_nxt = ppmd_pkg::ST_IGNORED;
    seen_nxt   = {1'b0, idx_r};
    store_en   = 1'b0;
    done       = 1'b0;

    priority if (!hit) begin
    end else if (!ready_r) begin
      if (gap) begin
        ready_nxt  = 1'b1;
        idx_nxt    = '0;
        sync_nxt   = 1'b0;
        status_nxt = ppmd_pkg::ST_SYNC;
        seen_nxt   = 4'd0;
      end
    end else if (gap) begin
      idx_nxt    = '0;
      sync_nxt   = 1'b1;
      status_nxt = ppmd_pkg::ST_SYNC;
      seen_nxt   = 4'd0;
    end else if (bad) begin
      ready_nxt  = 1'b0;
      idx_nxt    = '0;
      status_nxt = ppmd_pkg::ST_BADWIDTH;
      seen_nxt   = 4'd0;
    end else if (jump) begin
      ready_nxt  = 1'b0;
      idx_nxt    = '0;
      status_nxt = ppmd_pkg::ST_JUMP;
      seen_nxt   = 4'd0;
    end else if (idx_r == CW'(NC - 1)) begin
      store_en   = 1'b1;
      done       = 1'b1;
      ready_nxt  = 1'b0;
      idx_nxt    = '0;
      status_nxt = ppmd_pkg::ST_DONE;
      seen_nxt   = 4'(NC);
    end else begin
      store_en   = 1'b1;
      idx_nxt    = idx_r + CW'(1);
      status_nxt = ppmd_pkg::ST_STORED;
      seen_nxt   = {1'b0, idx_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= 32'd0;
      ready_r     <= 1'b0;
      idx_r       <= '0;
      sync_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        last_r[i]   <= ppmd_pkg::LAST_RESET;
        mapped_r[i] <= 16'd0;
      end
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        ready_r <= ready_nxt;
        idx_r   <= idx_nxt;
        sync_r  <= sync_nxt;
        if (hit) begin
          prev_time_r <= item_time;
        end
        if (store_en) begin
          last_r[idx_r] <= val;
        end
        if (done) begin
          for (int i = 0; i < NC; i++) begin
            mapped_r[i] <= (ppmd_pkg::map_src(CW'(i)) == idx_r) ? val
                           : store_r[ppmd_pkg::map_src(CW'(i))];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status_nxt;
      seen_r   <= seen_nxt;
      if (store_en) begin
        store_r[idx_r] <= val;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_channels_seen = seen_r;
  assign out_sync_flag     = sync_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      out_mapped[i] = mapped_r[i];
    end
  end

  a_done_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ppmd_pkg::ST_DONE) |-> (!ready_r && idx_r == '0 && seen_r == 4'(NC)))
    else $error("frame done left decoder armed");

  a_stored_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ppmd_pkg::ST_STORED)
      |-> (ready_r && idx_r != '0 && seen_r == {1'b0, idx_r}))
    else $error("stored item disagrees with channel index");

  a_sync_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ppmd_pkg::ST_SYNC) |-> (ready_r && idx_r == '0 && seen_r == 4'd0))
    else $error("sync item did not arm decoder");

  a_reject_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ppmd_pkg::ST_JUMP || status_r == ppmd_pkg::ST_BADWIDTH))
      |-> (!ready_r && idx_r == '0))
    else $error("rejected channel kept frame");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> ($stable(ready_r) && $stable(idx_r) && $stable(prev_time_r)))
    else $error("decode state moved without an item");

endmodule

[rtl/ppm_frame_decoder_glitch_filter_unit.sv]
// Top level of the PPM frame decoder with per-channel glitch filter.
// Throughput: one item per cycle unless out_ready stalls the output; the
// decode state is updated once per item, so items may follow each other back
// to back.
// Reset (rst_n, synchronous, active low): registers return to defaults, last
// accepted values to 1500, mapped outputs to zero, both channels empty.
module ppm_frame_decoder_glitch_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_edge_pin,
  input  logic [31:0] in_edge_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_channels_seen,
  output logic        out_sync_flag,
  output logic [15:0] out_left_x,
  output logic [15:0] out_left_y,
  output logic [15:0] out_right_x,
  output logic [15:0] out_right_y,
  output logic [15:0] out_switch_a,
  output logic [15:0] out_switch_b,
  output logic [15:0] out_switch_c,
  output logic [15:0] out_switch_d
);

  ppmd_pkg::cfg_t cfg;
  logic           in_valid_r;
  logic [15:0]    pin_r;
  logic [31:0]    time_r;
  logic           take;
  logic [ppmd_pkg::CHANNELS-1:0][15:0] mapped;

  assign in_ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pin_r  <= in_edge_pin;
      time_r <= in_edge_time;
    end
  end

  ppmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppmd_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .item_valid        (in_valid_r),
    .item_pin          (pin_r),
    .item_time         (time_r),
    .take              (take),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_channels_seen (out_channels_seen),
    .out_sync_flag     (out_sync_flag),
    .out_mapped        (mapped)
  );

  assign out_left_x   = mapped[0];
  assign out_left_y   = mapped[1];
  assign out_right_x  = mapped[2];
  assign out_right_y  = mapped[3];
  assign out_switch_a = mapped[4];
  assign out_switch_b = mapped[5];
  assign out_switch_c = mapped[6];
  assign out_switch_d = mapped[7];

endmodule

[bench/ppm_decode_scoreboard.sv]
// Scoreboard class: predicts the decoder's report for each edge and checks returned reports.
package ppm_decode_scoreboard_pkg;

  class ppm_decode_scoreboard;
    typedef struct packed {
      ppmd_pkg::status_t status;
      logic [3:0]        seen;
      logic              sync;
      logic [7:0][15:0]  sticks;
    } decode_report_t;

    logic [15:0] watch;
    logic [19:0] gap_min;
    logic [15:0] pmin;
    logic [15:0] pmax;
    logic [6:0]  pct;

    logic [31:0]      prev_time;
    bit               armed;
    logic [3:0]       chan_idx;
    bit               sync_seen;
    logic [15:0]      store [8];
    logic [15:0]      last_acc [8];
    logic [7:0][15:0] sticks;

    int unsigned stick_src [8] = '{0, 1, 3, 2, 4, 5, 6, 7};
    string stick_names [8] = '{"left_x", "left_y", "right_x", "right_y",
                               "switch_a", "switch_b", "switch_c", "switch_d"};

    decode_report_t pending_reports [$];
    int errors;

    function new();
      watch     = 16'd256;
      gap_min   = 20'd2500;
      pmin      = 16'd1000;
      pmax      = 16'd2000;
      pct       = 7'd15;
      prev_time = '0;
      armed     = 1'b0;
      chan_idx  = '0;
      sync_seen = 1'b0;
      sticks    = '0;
      errors    = 0;
      for (int i = 0; i < 8; i++) begin
        store[i]    = '0;
        last_acc[i] = 16'd1500;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        ppmd_pkg::REG_WATCHED_PIN:   watch   = value[15:0];
        ppmd_pkg::REG_FRAME_GAP_MIN: gap_min = value[19:0];
        ppmd_pkg::REG_PULSE_MIN:     pmin    = value[15:0];
        ppmd_pkg::REG_PULSE_MAX:     pmax    = value[15:0];
        ppmd_pkg::REG_JUMP_PERCENT:  pct     = value[6:0];
        default: ;
      endcase
    endfunction

    function void queue_report(ppmd_pkg::status_t status, logic [3:0] seen);
      decode_report_t rep;
      rep.status = status;
      rep.seen   = seen;
      rep.sync   = sync_seen;
      rep.sticks = sticks;
      pending_reports.push_back(rep);
    endfunction

    function void note_edge(logic [15:0] pin, logic [31:0] stamp);
      logic [31:0] delta;
      logic [31:0] thr;
      logic [31:0] diff;
      logic [15:0] val;
      logic [15:0] old;
      logic [2:0]  idx;
      if (pin != watch) begin
        queue_report(ppmd_pkg::ST_IGNORED, chan_idx);
        return;
      end
      delta     = stamp - prev_time;
      prev_time = stamp;
      if (!armed) begin
        if (delta >= 32'(gap_min)) begin
          armed     = 1'b1;
          chan_idx  = '0;
          sync_seen = 1'b0;
          queue_report(ppmd_pkg::ST_SYNC, 4'd0);
        end else begin
          queue_report(ppmd_pkg::ST_IGNORED, chan_idx);
        end
        return;
      end
      if (delta >= 32'(gap_min)) begin
        chan_idx  = '0;
        sync_seen = 1'b1;
        queue_report(ppmd_pkg::ST_SYNC, 4'd0);
        return;
      end
      if (delta < 32'(pmin) || delta > 32'(pmax)) begin
        armed    = 1'b0;
        chan_idx = '0;
        queue_report(ppmd_pkg::ST_BADWIDTH, 4'd0);
        return;
      end
      val = delta[15:0];
      idx = chan_idx[2:0];
      old = last_acc[idx];
      if (idx != 0 && old != 0) begin
        thr  = (32'(old) * 32'(pct)) / 32'd100;
        diff = (val >= old) ? 32'(val - old) : 32'(old - val);
        if (diff > thr) begin
          armed    = 1'b0;
          chan_idx = '0;
          queue_report(ppmd_pkg::ST_JUMP, 4'd0);
          return;
        end
      end
      store[idx]    = val;
      last_acc[idx] = val;
      chan_idx      = 4'(idx) + 4'd1;
      if (chan_idx >= 4'd8) begin
        for (int i = 0; i < 8; i++) sticks[i] = store[stick_src[i]];
        armed    = 1'b0;
        chan_idx = '0;
        queue_report(ppmd_pkg::ST_DONE, 4'd8);
        return;
      end
      queue_report(ppmd_pkg::ST_STORED, chan_idx);
    endfunction

    function void check_report(logic [2:0] status, logic [3:0] seen, logic sync,
                               logic [7:0][15:0] got_sticks);
      decode_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $error("report with no pending item: status %0d", status);
        return;
      end
      want = pending_reports.pop_front();
      if (status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, status);
      end
      if (seen !== want.seen) begin
        errors++;
        $error("channels_seen: expected %0d, got %0d", want.seen, seen);
      end
      if (sync !== want.sync) begin
        errors++;
        $error("sync_flag: expected %0d, got %0d", want.sync, sync);
      end
      for (int i = 0; i < 8; i++) begin
        if (got_sticks[i] !== want.sticks[i]) begin
          errors++;
          $error("%s: expected %0d, got %0d", stick_names[i], want.sticks[i], got_sticks[i]);
        end
      end
    endfunction
  endclass

endpackage

[bench/testbench.sv]
// Top-level bench for the PPM frame decoder: stimulus, handshakes, register port and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_QUOTA = 245;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_edge_pin = '0;
  logic [31:0] in_edge_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_channels_seen;
  logic        out_sync_flag;
  logic [15:0] out_left_x;
  logic [15:0] out_left_y;
  logic [15:0] out_right_x;
  logic [15:0] out_right_y;
  logic [15:0] out_switch_a;
  logic [15:0] out_switch_b;
  logic [15:0] out_switch_c;
  logic [15:0] out_switch_d;

  ppm_decode_scoreboard_pkg::ppm_decode_scoreboard sb;
  int burst_left = 0;
  int decoded = 0;
  int quiet = 0;
  int rx_mode = 0;
  int rx_left = 0;

  ppm_frame_decoder_glitch_filter_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_edge_pin       (in_edge_pin),
    .in_edge_time      (in_edge_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_channels_seen (out_channels_seen),
    .out_sync_flag     (out_sync_flag),
    .out_left_x        (out_left_x),
    .out_left_y        (out_left_y),
    .out_right_x       (out_right_x),
    .out_right_y       (out_right_y),
    .out_switch_a      (out_switch_a),
    .out_switch_b      (out_switch_b),
    .out_switch_c      (out_switch_c),
    .out_switch_d      (out_switch_d)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_report(out_status, out_channels_seen, out_sync_flag,
                      {out_switch_d, out_switch_c, out_switch_b, out_switch_a,
                       out_right_y, out_right_x, out_left_y, out_left_x});
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_edge(input logic [15:0] pin, input logic [31:0] stamp);
    int pause;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      pause = $urandom_range(0, 5);
      if (pause != 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_edge_pin  <= pin;
    in_edge_time <= stamp;
    do @(posedge clk); while (!in_ready);
    if (pin == sb.watch) decoded++;
    sb.note_edge(pin, stamp);
  endtask

  task automatic send_watched(input int delta);
    send_edge(sb.watch, sb.prev_time + 32'(delta));
  endtask

  task automatic send_noise();
    logic [15:0] pin;
    pin = 16'($urandom);
    if (pin == sb.watch) pin = ~pin;
    send_edge(pin, $urandom);
  endtask

  task automatic send_gap();
    send_watched(int'(sb.gap_min) + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000)));
  endtask

  function automatic int clean_width();
    int lo;
    int hi;
    int old;
    int thr;
    lo = int'(sb.pmin);
    hi = int'(sb.pmax);
    if (hi >= int'(sb.gap_min)) hi = int'(sb.gap_min) - 1;
    old = int'(sb.last_acc[sb.chan_idx[2:0]]);
    if (sb.chan_idx != 0 && old != 0) begin
      thr = old * int'(sb.pct) / 100;
      if (old - thr > lo) lo = old - thr;
      if (old + thr < hi) hi = old + thr;
    end
    if (lo > hi) return int'(sb.pmin);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic clean_frame();
    send_gap();
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_watched(clean_width());
    end
  endtask

  task automatic broken_frame();
    int lo;
    int hi;
    int old;
    int thr;
    send_gap();
    repeat ($urandom_range(0, 7)) send_watched(clean_width());
    case ($urandom_range(0, 4))
      0: send_watched(sb.pmin == 0 ? 0 : $urandom_range(0, sb.pmin - 1));
      1: begin
        lo = int'(sb.pmax) + 1;
        hi = int'(sb.gap_min) - 1;
        send_watched(lo <= hi ? $urandom_range(hi, lo) : lo);
      end
      2: begin
        old = int'(sb.last_acc[sb.chan_idx[2:0]]);
        thr = old * int'(sb.pct) / 100;
        hi  = old + thr + 1 + $urandom_range(0, 50);
        lo  = old - thr - 1 - $urandom_range(0, 50);
        send_watched(($urandom_range(0, 1) == 1 && lo >= 0) ? lo : hi);
      end
      3: clean_frame();
      default: send_watched($urandom);
    endcase
    repeat ($urandom_range(0, 3)) begin
      if (sb.gap_min > 1) send_watched($urandom_range(0, sb.gap_min - 1));
    end
  endtask

  task automatic random_phase(input int quota);
    int goal;
    goal = decoded + quota;
    while (decoded < goal) begin
      case ($urandom_range(0, 19))
        0, 1:          repeat ($urandom_range(1, 4)) send_noise();
        2, 3, 4, 5, 6: broken_frame();
        default:       clean_frame();
      endcase
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_set(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      sb.errors++;
      $error("register %0d: expected %0h, got %0h", idx, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] pin_mask, input logic [19:0] gap,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input logic [6:0] pct);
    drain();
    reg_set(ppmd_pkg::REG_WATCHED_PIN, 32'(pin_mask));
    reg_set(ppmd_pkg::REG_FRAME_GAP_MIN, 32'(gap));
    reg_set(ppmd_pkg::REG_PULSE_MIN, 32'(lo));
    reg_set(ppmd_pkg::REG_PULSE_MAX, 32'(hi));
    reg_set(ppmd_pkg::REG_JUMP_PERCENT, 32'(pct));
  endtask

  initial begin
    logic [15:0] pin_mask;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [19:0] gap;
    logic [6:0]  pct;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_watched(1000);
    send_edge(16'h0101, 32'd77);
    send_watched(2500);
    send_watched(1000);
    send_watched(1725);
    send_watched(1275);
    send_watched(1726);
    send_watched(3000);
    send_watched(2000);
    send_watched(9000);
    for (int k = 0; k < 8; k++) begin
      send_watched(k == 0 ? 1500 : int'(sb.last_acc[sb.chan_idx[2:0]]));
    end
    send_edge(sb.watch, 32'hFFFF_FF00);
    send_watched(2001);

    configure(16'hFFFF, 20'hFFFFF, 16'h0000, 16'hFFFF, 7'd127);
    send_watched(32'h0010_0000);
    send_watched(65535);
    send_watched(0);
    send_watched(32'h0010_0000);
    send_watched(0);
    send_watched(65535);
    send_watched(32'h0010_0000);

    configure(16'h0000, 20'd1, 16'hFFFF, 16'h0000, 7'd0);
    send_watched(5);
    send_watched(0);
    drain();
    reg_set(ppmd_pkg::REG_FRAME_GAP_MIN, 32'd0);
    send_watched(0);
    send_watched(0);

    for (int p = 0; p < 6; p++) begin
      pin_mask = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom);
      lo  = (p == 2) ? 16'd0 : (p == 1) ? 16'd60000 : 16'($urandom_range(1, 3000));
      hi  = (p == 1) ? 16'hFFFF : lo + 16'($urandom_range(0, 2500));
      gap = (p == 1) ? 20'hFFFFF : 20'(hi) + 20'($urandom_range(1, 5000));
      pct = (p == 3) ? 7'd0 : (p == 4) ? 7'd127 : (p == 5) ? 7'd100
          : 7'($urandom_range(0, 127));
      configure(pin_mask, gap, lo, hi, pct);
      random_phase(PHASE_QUOTA);
    end

    drain();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ppmd_pkg.sv
rtl/ppmd_cfg.sv
rtl/ppmd_core.sv
rtl/ppm_frame_decoder_glitch_filter_unit.sv
bench/ppm_decode_scoreboard.sv
bench/testbench.sv
